@@ hw/rtl/slist_pkg.sv @@
`default_nettype none

package slist_pkg;

	localparam int MODE_W   = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;

	// request modes
	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND       = 3'd0,
		MODE_PREPEND      = 3'd1,
		MODE_REMOVE_LAST  = 3'd2,
		MODE_REMOVE_FIRST = 3'd3,
		MODE_INSERT_AT    = 3'd4,
		MODE_ERASE_AT     = 3'd5,
		MODE_FIND         = 3'd6
	} mode_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_e;

	// datapath operations
	typedef enum logic [2:0] {
		DP_NONE      = 3'd0,
		DP_INSERT    = 3'd1,
		DP_ERASE     = 3'd2,
		DP_DROP      = 3'd3,
		DP_FIND_LOAD = 3'd4,
		DP_FIND_STEP = 3'd5
	} dp_op_e;

	// where an insert or erase takes place
	typedef enum logic [1:0] {
		AT_POS   = 2'd0,
		AT_ZERO  = 2'd1,
		AT_COUNT = 2'd2
	} at_sel_e;

	typedef struct packed {
		dp_op_e  op;
		at_sel_e at_sel;
		logic    result_load;
		status_e status;
		logic    hit;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_gt_count;
		logic pos_ge_count;
		logic scan_hit;
		logic scan_none;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/slist_datapath.sv @@
`default_nettype none

module slist_datapath #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire slist_pkg::dp_cmd_t                   cmd,
	input  wire logic [slist_pkg::POS_W-1:0]          position,
	input  wire logic signed [slist_pkg::WORD_W-1:0]  value,
	output slist_pkg::dp_stat_t                       stat,
	output logic [slist_pkg::STATUS_W-1:0]            status,
	output logic                                      match_found,
	output logic [slist_pkg::INDEX_W-1:0]             match_index,
	output logic [slist_pkg::COUNT_W-1:0]             entry_count
);
	import slist_pkg::*;

	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int IW   = $clog2(LIST_DEPTH);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic signed [WORD_W-1:0] cell_q [LIST_DEPTH];
	logic signed [WORD_W-1:0] cell_d [LIST_DEPTH];
	logic [CW-1:0]            count_q;
	logic [LIST_DEPTH-1:0]    match_q;
	logic [LIST_DEPTH-1:0]    match_d;
	logic [IW-1:0]            scan_idx_q;
	logic [IW-1:0]            at_idx;
	status_e                  status_q;
	logic                     found_q;
	logic [INDEX_W-1:0]       index_q;

	always_comb begin
		case (cmd.at_sel)
			AT_ZERO:  at_idx = '0;
			AT_COUNT: at_idx = IW'(count_q);
			default:  at_idx = IW'(position);
		endcase
	end

	// every cell looks only at itself and its two neighbors
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			case (cmd.op)
				DP_INSERT: begin
					if (IW'(i) == at_idx)
						cell_d[i] = value;
					else if (IW'(i) > at_idx)
						cell_d[i] = cell_q[(i == 0) ? 0 : i - 1];
				end
				DP_ERASE: begin
					if (IW'(i) >= at_idx)
						cell_d[i] = cell_q[(i == LIST_DEPTH - 1) ? i : i + 1];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	// local compare in each cell, then the match row shifts out one bit a cycle during a find scan
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++)
			match_d[i] = (cell_q[i] == value) && (CW'(i) < count_q);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_FIND_LOAD: begin
				match_q    <= match_d;
				scan_idx_q <= '0;
			end
			DP_FIND_STEP: begin
				match_q    <= match_q >> 1;
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				DP_INSERT:         count_q <= count_q + CW'(1);
				DP_ERASE, DP_DROP: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			status_q <= cmd.status;
			found_q  <= cmd.hit;
			index_q  <= cmd.hit ? INDEX_W'(scan_idx_q) : '0;
		end
	end

	assign stat.full         = (count_q == CW'(LIST_DEPTH));
	assign stat.empty        = (count_q == '0);
	assign stat.pos_gt_count = (CMPW'(position) > CMPW'(count_q));
	assign stat.pos_ge_count = (CMPW'(position) >= CMPW'(count_q));
	assign stat.scan_hit     = match_q[0];
	assign stat.scan_none    = ~|match_q;

	assign status      = status_q;
	assign match_found = found_q;
	assign match_index = index_q;
	assign entry_count = COUNT_W'(count_q);

endmodule

`default_nettype wire

@@ hw/rtl/slist_ctrl.sv @@
`default_nettype none

module slist_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [slist_pkg::MODE_W-1:0]  mode,
	input  wire slist_pkg::dp_stat_t           stat,
	output slist_pkg::dp_cmd_t                 cmd,
	output logic                               out_valid,
	input  wire logic                          out_ready
);
	import slist_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d         = state_q;
		cmd.op          = DP_NONE;
		cmd.at_sel      = AT_POS;
		cmd.result_load = 1'b0;
		cmd.status      = ST_OK;
		cmd.hit         = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.result_load = 1'b1;
					case (mode)
						MODE_APPEND: begin
							if (stat.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.op     = DP_INSERT;
								cmd.at_sel = AT_COUNT;
							end
						end
						MODE_PREPEND: begin
							if (stat.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.op     = DP_INSERT;
								cmd.at_sel = AT_ZERO;
							end
						end
						MODE_REMOVE_LAST: begin
							if (stat.empty)
								cmd.status = ST_EMPTY;
							else
								cmd.op = DP_DROP;
						end
						MODE_REMOVE_FIRST: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.op     = DP_ERASE;
								cmd.at_sel = AT_ZERO;
							end
						end
						MODE_INSERT_AT: begin
							// position check wins over the full check
							if (stat.pos_gt_count)
								cmd.status = ST_BADPOS;
							else if (stat.full)
								cmd.status = ST_FULL;
							else
								cmd.op = DP_INSERT;
						end
						MODE_ERASE_AT: begin
							if (stat.empty)
								cmd.status = ST_EMPTY;
							else if (stat.pos_ge_count)
								cmd.status = ST_BADPOS;
							else
								cmd.op = DP_ERASE;
						end
						MODE_FIND: begin
							cmd.result_load = 1'b0;
							cmd.op          = DP_FIND_LOAD;
							state_d         = S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (stat.scan_none) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.scan_hit) begin
					cmd.result_load = 1'b1;
					cmd.hit         = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.op = DP_FIND_STEP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/sequential_list_engine_core.sv @@
// Packed ordered list of up to LIST_DEPTH signed 32-bit words. Each request
// picks a mode: append, prepend, remove last, remove first, insert at
// position, erase at position, or find. Every request returns exactly one
// result: status (ok, full, empty, bad position), match_found/match_index for
// find, and entry_count after the request. A request that cannot be served
// leaves the list untouched. Timing: all modes except find finish in the cycle
// they are accepted and the result shows the next cycle, because the storage
// is a row of cells that shift up or down in parallel. A find compares every
// cell at once, then walks the match row one bit per cycle until the lowest
// hit, so its run grows with the index of the lowest hit, and a miss ends on
// the first scan step. One request is in flight at a time; a new one is taken
// while the previous result still waits on the output register, as long as
// that result is drained in the same cycle. There is no clearing pass after
// reset: the count alone marks which cells are live.

`default_nettype none

module sequential_list_engine_core #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// request channel
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [slist_pkg::MODE_W-1:0]         mode,
	input  wire logic [slist_pkg::POS_W-1:0]          position,
	input  wire logic signed [slist_pkg::WORD_W-1:0]  value,
	// result channel
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [slist_pkg::STATUS_W-1:0]            status,
	output logic                                      match_found,
	output logic [slist_pkg::INDEX_W-1:0]             match_index,
	output logic [slist_pkg::COUNT_W-1:0]             entry_count
);
	import slist_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing: decodes the request against list state, runs the find scan
	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.stat      (stat),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	// cells, count, match row and result register
	slist_datapath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.stat        (stat),
		.status      (status),
		.match_found (match_found),
		.match_index (match_index),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

@@ hw/rtl/slist_checker.sv @@
`default_nettype none

module slist_props (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [slist_pkg::MODE_W-1:0]      mode,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [slist_pkg::STATUS_W-1:0]    status,
	input wire logic                              match_found,
	input wire logic [slist_pkg::INDEX_W-1:0]     match_index,
	input wire logic [slist_pkg::COUNT_W-1:0]     entry_count
);
	import slist_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(match_found)
			&& $stable(match_index) && $stable(entry_count))
		else $error("result changed while stalled");

	// every request other than find answers in the next cycle
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode != MODE_FIND) |=> out_valid)
		else $error("non-find request gave no result in the next cycle");

	// a find passes through the scan state before its result shows
	a_find_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_FIND) |=> !out_valid)
		else $error("find result showed too early");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_found |-> status == ST_OK)
		else $error("match reported with a failing status");

	a_fail_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> !match_found && (match_index == '0))
		else $error("failing request reported match data");

endmodule

bind sequential_list_engine_core slist_props u_slist_props (.*);

`default_nettype wire
